[rtl/lebe_pkg.sv]
// shared types, constants and helpers for the line edit buffer engine
// used by lebe_seq and line_edit_buffer_engine; no dependencies
`timescale 1ns / 1ps

package lebe_pkg;

  localparam int CAPACITY   = 256;
  localparam int AW         = $clog2(CAPACITY);
  localparam int PW         = 9;
  localparam int DW         = 8;
  localparam int SPAN_W     = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  localparam logic [PW-1:0] CAP_POS = PW'(CAPACITY);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [DW-1:0] UNDERSCORE = 8'h5F;

  typedef enum logic [3:0] {
    OP_CLEAR     = 4'd0,
    OP_INSERT    = 4'd1,
    OP_BKSP      = 4'd2,
    OP_DELETE    = 4'd3,
    OP_SPAN      = 4'd4,
    OP_LEFT      = 4'd5,
    OP_RIGHT     = 4'd6,
    OP_HOME      = 4'd7,
    OP_END       = 4'd8,
    OP_NWS_MOVE  = 4'd9,
    OP_PWS_MOVE  = 4'd10,
    OP_WE_MOVE   = 4'd11,
    OP_NWS_QUERY = 4'd12,
    OP_PWS_QUERY = 4'd13,
    OP_WE_QUERY  = 4'd14,
    OP_READ      = 4'd15
  } op_e;

  // op sits in the lowest bits
  typedef struct packed {
    logic [7:0]        read_index;
    logic [SPAN_W-1:0] span_stop;
    logic [SPAN_W-1:0] span_start;
    logic [DW-1:0]     char_in;
    op_e               op;
  } cmd_t;

  // status sits in the lowest bits
  typedef struct packed {
    logic [DW-1:0] char_out;
    logic [PW-1:0] word_target;
    logic [PW-1:0] length_out;
    logic [PW-1:0] cursor_out;
    logic [1:0]    status;
  } res_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [DW-1:0] data;
  } mem_wr_t;

  function automatic logic is_word(input logic [DW-1:0] c);
    is_word = ((c >= 8'h30) && (c <= 8'h39)) ||
              ((c >= 8'h41) && (c <= 8'h5A)) ||
              ((c >= 8'h61) && (c <= 8'h7A)) ||
              (c == UNDERSCORE);
  endfunction

endpackage

[rtl/lebe_text_ram.sv]
// generic simple dual-port ram: one write port, one read port, registered read data
// no dependencies
`timescale 1ns / 1ps

module lebe_text_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/lebe_seq.sv]
// command sequencer: holds cursor and length, shifts and scans the text ram
// depends on lebe_pkg
`timescale 1ns / 1ps

module lebe_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  lebe_pkg::cmd_t            cmd_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output lebe_pkg::res_t            res_o,
  output logic [lebe_pkg::AW-1:0]   mem_raddr_o,
  input  logic [lebe_pkg::DW-1:0]   mem_rdata_i,
  output lebe_pkg::mem_wr_t         mem_wr_o
);

  import lebe_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_MV_RD   = 8'b0000_0010,
    S_MV_WR   = 8'b0000_0100,
    S_PUT     = 8'b0000_1000,
    S_SC_RD   = 8'b0001_0000,
    S_SC_EV   = 8'b0010_0000,
    S_RD_WAIT = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  op_e           op_q, op_d;
  logic [DW-1:0] ch_q, ch_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [PW-1:0] dist_q, dist_d;
  logic          phase_q, phase_d;
  logic [PW-1:0] cur_q, cur_d;
  logic [PW-1:0] len_q, len_d;
  logic [1:0]    status_q, status_d;
  logic [PW-1:0] target_q, target_d;
  logic [DW-1:0] char_q, char_d;

  logic kind_nws, kind_pws, is_move, shift_down;

  assign kind_nws   = (op_q == OP_NWS_MOVE) || (op_q == OP_NWS_QUERY);
  assign kind_pws   = (op_q == OP_PWS_MOVE) || (op_q == OP_PWS_QUERY);
  assign is_move    = (op_q == OP_NWS_MOVE) || (op_q == OP_PWS_MOVE) || (op_q == OP_WE_MOVE);
  assign shift_down = (op_q == OP_INSERT);

  always_comb begin
    logic [SPAN_W-1:0] len_w, a_w, b_w;
    logic [PW-1:0]     lo, hi, ptr_inc, ptr_dec, sc_addr;
    logic              rm, bound, cont;

    state_d  = state_q;
    op_d     = op_q;
    ch_d     = ch_q;
    ptr_d    = ptr_q;
    dist_d   = dist_q;
    phase_d  = phase_q;
    cur_d    = cur_q;
    len_d    = len_q;
    status_d = status_q;
    target_d = target_q;
    char_d   = char_q;

    cmd_ready_o = (state_q == S_IDLE);
    res_valid_o = 1'b0;
    mem_raddr_o = ptr_q[AW-1:0];
    mem_wr_o    = '0;

    len_w   = SPAN_W'(len_q);
    a_w     = '0;
    b_w     = '0;
    lo      = '0;
    hi      = '0;
    rm      = 1'b0;
    bound   = 1'b0;
    cont    = 1'b0;
    sc_addr = ptr_q;
    ptr_inc = ptr_q + PW'(1);
    ptr_dec = ptr_q - PW'(1);

    unique case (state_q)
      S_IDLE: begin
        // a read command fetches its byte in the accept cycle
        mem_raddr_o = cmd_i.read_index;
        if (cmd_valid_i) begin
          op_d     = cmd_i.op;
          ch_d     = cmd_i.char_in;
          status_d = ST_OK;
          target_d = '0;
          char_d   = '0;
          phase_d  = 1'b0;
          state_d  = S_DONE;
          unique case (cmd_i.op)
            OP_CLEAR: begin
              len_d = '0;
              cur_d = '0;
            end
            OP_INSERT: begin
              if (len_q == CAP_POS) begin
                status_d = ST_FULL;
              end else begin
                ptr_d   = len_q;
                state_d = (len_q > cur_q) ? S_MV_RD : S_PUT;
              end
            end
            OP_BKSP: begin
              if (cur_q != '0) begin
                rm    = 1'b1;
                lo    = cur_q - PW'(1);
                hi    = cur_q;
                cur_d = cur_q - PW'(1);
              end
            end
            OP_DELETE: begin
              if (cur_q < len_q) begin
                rm = 1'b1;
                lo = cur_q;
                hi = cur_q + PW'(1);
              end
            end
            OP_SPAN: begin
              a_w = (cmd_i.span_start <= len_w) ? cmd_i.span_start : len_w;
              b_w = (cmd_i.span_stop <= len_w) ? cmd_i.span_stop : len_w;
              if (a_w > b_w) begin
                lo = b_w[PW-1:0];
                hi = a_w[PW-1:0];
              end else begin
                lo = a_w[PW-1:0];
                hi = b_w[PW-1:0];
              end
              cur_d = lo;
              rm    = (lo != hi);
            end
            OP_LEFT: begin
              if (cur_q != '0) cur_d = cur_q - PW'(1);
            end
            OP_RIGHT: begin
              if (cur_q < len_q) cur_d = cur_q + PW'(1);
            end
            OP_HOME: cur_d = '0;
            OP_END:  cur_d = len_q;
            OP_PWS_MOVE, OP_PWS_QUERY: begin
              if (cur_q != '0) begin
                ptr_d   = cur_q - PW'(1);
                state_d = S_SC_RD;
              end
            end
            OP_NWS_MOVE, OP_NWS_QUERY, OP_WE_MOVE, OP_WE_QUERY: begin
              ptr_d   = cur_q;
              state_d = S_SC_RD;
            end
            OP_READ: begin
              if (PW'(cmd_i.read_index) < len_q) begin
                state_d = S_RD_WAIT;
              end else begin
                status_d = ST_RANGE;
              end
            end
            default: state_d = S_DONE;
          endcase
          if (rm) begin
            ptr_d  = hi;
            dist_d = hi - lo;
            if (hi < len_q) begin
              state_d = S_MV_RD;
            end else begin
              len_d = len_q - (hi - lo);
            end
          end
        end
      end

      S_MV_RD: begin
        mem_raddr_o = shift_down ? ptr_dec[AW-1:0] : ptr_q[AW-1:0];
        state_d     = S_MV_WR;
      end

      // read and write addresses of consecutive steps never coincide
      S_MV_WR: begin
        mem_wr_o.we   = 1'b1;
        mem_wr_o.data = mem_rdata_i;
        if (shift_down) begin
          mem_wr_o.addr = ptr_q[AW-1:0];
          ptr_d         = ptr_dec;
          state_d       = (ptr_dec > cur_q) ? S_MV_RD : S_PUT;
        end else begin
          mem_wr_o.addr = AW'(ptr_q - dist_q);
          ptr_d         = ptr_inc;
          if (ptr_inc < len_q) begin
            state_d = S_MV_RD;
          end else begin
            len_d   = len_q - dist_q;
            state_d = S_DONE;
          end
        end
      end

      S_PUT: begin
        mem_wr_o.we   = 1'b1;
        mem_wr_o.addr = cur_q[AW-1:0];
        mem_wr_o.data = ch_q;
        cur_d         = cur_q + PW'(1);
        len_d         = len_q + PW'(1);
        state_d       = S_DONE;
      end

      S_SC_RD: begin
        if (kind_pws) begin
          bound   = (ptr_q != '0);
          sc_addr = phase_q ? ptr_dec : ptr_q;
        end else if (kind_nws || !phase_q) begin
          bound   = (ptr_q < len_q);
          sc_addr = ptr_q;
        end else begin
          bound   = (ptr_inc < len_q);
          sc_addr = ptr_inc;
        end
        if (bound) begin
          mem_raddr_o = sc_addr[AW-1:0];
          state_d     = S_SC_EV;
        end else begin
          target_d = ptr_q;
          if (is_move) cur_d = ptr_q;
          state_d = S_DONE;
        end
      end

      // keep going while the byte matches the class this phase skips over
      S_SC_EV: begin
        cont = is_word(mem_rdata_i) ^ phase_q ^ !kind_nws;
        if (cont) begin
          ptr_d   = kind_pws ? ptr_dec : ptr_inc;
          state_d = S_SC_RD;
        end else if (!phase_q) begin
          phase_d = 1'b1;
          state_d = S_SC_RD;
        end else begin
          target_d = ptr_q;
          if (is_move) cur_d = ptr_q;
          state_d = S_DONE;
        end
      end

      S_RD_WAIT: begin
        char_d  = mem_rdata_i;
        state_d = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.status      = status_q;
  assign res_o.cursor_out  = cur_q;
  assign res_o.length_out  = len_q;
  assign res_o.word_target = target_q;
  assign res_o.char_out    = char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q   <= '0;
      len_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      len_q   <= len_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    ch_q     <= ch_d;
    ptr_q    <= ptr_d;
    dist_q   <= dist_d;
    status_q <= status_d;
    target_q <= target_d;
    char_q   <= char_d;
  end

  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q)
    else $error("cursor beyond text length");

  a_len_in_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CAP_POS)
    else $error("text length beyond capacity");

  a_write_only_when_editing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_o.we |-> (state_q == S_MV_WR || state_q == S_PUT))
    else $error("ram write outside an edit");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_o && cmd_i.op == OP_CLEAR) |=> (len_q == '0 && cur_q == '0))
    else $error("clear left text behind");

endmodule

[rtl/line_edit_buffer_engine.sv]
// line edit buffer engine: top level with stream ports and the result register
// depends on lebe_pkg, lebe_text_ram and lebe_seq
//
// usage:
//   commands arrive on the s_axis channel, one per transaction; every command
//   yields exactly one result transaction on the m_axis channel.
//   a command is taken only while the sequencer is idle. cursor moves, clear,
//   a full insert and a bad read finish without touching the text ram; a read
//   waits for its byte from the ram; insert shifts the bytes from the cursor
//   up by one; backspace, delete and span shift the bytes after the end of
//   the span down; word moves and queries scan the text byte by byte. the
//   shift loop moves one byte per read and write through the single-read-port
//   text ram.
//   after reset the text is empty and the cursor is at 0; the text ram holds
//   no defined bytes until written and needs no clearing pass.
//   a finished result sits in the output register; the next command is taken
//   while it waits, and that command's result is held in the sequencer until
//   the receiver raises m_axis_tready_i.
`timescale 1ns / 1ps

module line_edit_buffer_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // op[3:0], char_in[11:4], span_start[27:12], span_stop[43:28], read_index[51:44]
  input  logic [lebe_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // status[1:0], cursor_out[10:2], length_out[19:11], word_target[28:20], char_out[36:29]
  output logic [lebe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  import lebe_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t          cmd;
  res_t          res;
  logic          res_valid, res_ready;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;
  mem_wr_t       mem_wr;

  logic          out_valid_q, out_valid_d;
  res_t          out_res_q;

  assign cmd = cmd_t'(s_axis_tdata_i[CMD_W-1:0]);

  lebe_text_ram #(
    .AW(AW),
    .DW(DW)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (mem_wr.we),
    .waddr_i (mem_wr.addr),
    .wdata_i (mem_wr.data),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lebe_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid_i),
    .cmd_ready_o (s_axis_tready_o),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_wr_o    (mem_wr)
  );

  // output register frees up as the receiver takes its transaction
  assign res_ready   = !out_valid_q || m_axis_tready_i;
  assign out_valid_d = (res_valid && res_ready) ||
                       (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - RES_W)'(0), out_res_q};

endmodule
